// ----- src/afu_pkg.sv -----
`default_nettype none

package afu_pkg;

   localparam int DataW   = 16;
   localparam int FracW   = 12;
   localparam int SlopeW  = 13;
   localparam int SegW    = 5;
   localparam int PosW    = DataW - SegW;
   localparam int TabW    = 12;
   localparam int CsrW    = 32;
   localparam int AddrW   = 3;
   localparam int WideW   = 40;

   typedef enum logic [1:0] {
      MODE_SIGMOID = 2'd0,
      MODE_TANH    = 2'd1,
      MODE_RELU    = 2'd2,
      MODE_LEAKY   = 2'd3
   } mode_type;

   typedef enum logic {
      CMD_FORWARD  = 1'b0,
      CMD_BACKWARD = 1'b1
   } cmd_type;

   typedef enum logic {
      CSR_MODE  = 1'b0,
      CSR_SLOPE = 1'b1
   } csr_index_type;

   localparam logic [SlopeW-1:0] SLOPE_RESET = 13'd41;
   localparam logic signed [16:0] ONE_Q = 17'sd4096;

   typedef struct packed {
      mode_type          mode;
      logic [SlopeW-1:0] slope;
   } cfg_type;

   // Sigmoid breakpoints at x = -8 + 0.5*i, scaled by 2^12 and rounded.
   function automatic logic [TabW-1:0] sig_point(input logic [SegW:0] idx);
      case (idx)
         6'd0:    sig_point = 12'd1;
         6'd1:    sig_point = 12'd2;
         6'd2:    sig_point = 12'd4;
         6'd3:    sig_point = 12'd6;
         6'd4:    sig_point = 12'd10;
         6'd5:    sig_point = 12'd17;
         6'd6:    sig_point = 12'd27;
         6'd7:    sig_point = 12'd45;
         6'd8:    sig_point = 12'd74;
         6'd9:    sig_point = 12'd120;
         6'd10:   sig_point = 12'd194;
         6'd11:   sig_point = 12'd311;
         6'd12:   sig_point = 12'd488;
         6'd13:   sig_point = 12'd747;
         6'd14:   sig_point = 12'd1102;
         6'd15:   sig_point = 12'd1546;
         6'd16:   sig_point = 12'd2048;
         6'd17:   sig_point = 12'd2550;
         6'd18:   sig_point = 12'd2994;
         6'd19:   sig_point = 12'd3349;
         6'd20:   sig_point = 12'd3608;
         6'd21:   sig_point = 12'd3785;
         6'd22:   sig_point = 12'd3902;
         6'd23:   sig_point = 12'd3976;
         6'd24:   sig_point = 12'd4022;
         6'd25:   sig_point = 12'd4051;
         6'd26:   sig_point = 12'd4069;
         6'd27:   sig_point = 12'd4079;
         6'd28:   sig_point = 12'd4086;
         6'd29:   sig_point = 12'd4090;
         6'd30:   sig_point = 12'd4092;
         6'd31:   sig_point = 12'd4094;
         default: sig_point = 12'd4095;
      endcase
   endfunction

   function automatic logic signed [DataW-1:0] sat16(input logic signed [WideW-1:0] v);
      if (v > 40'sd32767) begin
         sat16 = 16'sd32767;
      end else if (v < -40'sd32768) begin
         sat16 = $signed(16'h8000);
      end else begin
         sat16 = v[DataW-1:0];
      end
   endfunction

endpackage

`default_nettype wire

// ----- src/afu_req_if.sv -----
`default_nettype none

interface afu_req_if
   import afu_pkg::*;
();
   logic                    valid;
   logic                    ready;
   logic                    cmd;
   logic signed [DataW-1:0] value;
   logic signed [DataW-1:0] grad;

   modport source (output valid, cmd, value, grad, input ready);
   modport sink (input valid, cmd, value, grad, output ready);
endinterface

`default_nettype wire

// ----- src/afu_rsp_if.sv -----
`default_nettype none

interface afu_rsp_if
   import afu_pkg::*;
();
   logic                    valid;
   logic                    ready;
   logic signed [DataW-1:0] result;

   modport source (output valid, result, input ready);
   modport sink (input valid, result, output ready);
endinterface

`default_nettype wire

// ----- src/activation_function_unit.sv -----
// Activation unit on signed Q4.12 values, one item per cycle unless stalled.
// An item arrives on req_bus with cmd, value and grad. A forward item (cmd 0)
// returns the activation of value: sigmoid by a 32-segment interpolation,
// tanh, ReLU or leaky ReLU, as the mode register selects. A backward item
// (cmd 1) takes value as the saved output and returns its derivative times
// grad, saturated to 16 bits. Every item yields one item on rsp_bus.
// The mode register lies at address 0 and the leak slope at address 4 of the
// csr port; the user must write both only while no item is in flight, since
// the block does not enforce it. An accepted item passes four register stages
// (argument and table index, table read and first multiplier, interpolation
// and derivative, second multiplier and output register) to reach rsp_bus.
// Throughput is one item per cycle while the receiver does not stall.
// Reset empties the pipeline and sets sigmoid mode with a leak slope of 41.
// When the receiver stalls, the output holds and each stage fills in turn;
// once all are full, req_bus.ready falls, and no item is lost or repeated.
`default_nettype none

module activation_function_unit
   import afu_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   afu_req_if.sink               req_bus,
   afu_rsp_if.source             rsp_bus,
   input  wire logic             csr_psel,
   input  wire logic             csr_penable,
   input  wire logic             csr_pwrite,
   input  wire logic [AddrW-1:0] csr_paddr,
   input  wire logic [CsrW-1:0]  csr_pwdata,
   output logic      [CsrW-1:0]  csr_prdata,
   output logic                  csr_pready
);

   cfg_type cfg;

   afu_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   afu_pipe u_pipe (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

endmodule

`default_nettype wire

// ----- src/afu_csr.sv -----
`default_nettype none

module afu_csr
   import afu_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_psel,
   input  wire logic             csr_penable,
   input  wire logic             csr_pwrite,
   input  wire logic [AddrW-1:0] csr_paddr,
   input  wire logic [CsrW-1:0]  csr_pwdata,
   output logic      [CsrW-1:0]  csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   mode_type          mode_ff;
   logic [SlopeW-1:0] slope_ff;
   logic              wr_en;
   csr_index_type     index;

   assign index      = csr_index_type'(csr_paddr[2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_SIGMOID;
         slope_ff <= SLOPE_RESET;
      end else if (wr_en) begin
         case (index)
            CSR_MODE:  mode_ff  <= mode_type'(csr_pwdata[1:0]);
            CSR_SLOPE: slope_ff <= csr_pwdata[SlopeW-1:0];
            default:   mode_ff  <= mode_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         CSR_MODE:  csr_prdata = {{(CsrW-2){1'b0}}, mode_ff};
         CSR_SLOPE: csr_prdata = {{(CsrW-SlopeW){1'b0}}, slope_ff};
         default:   csr_prdata = '0;
      endcase
   end

   assign cfg.mode  = mode_ff;
   assign cfg.slope = slope_ff;

endmodule

`default_nettype wire

// ----- src/afu_pipe.sv -----
`default_nettype none

module afu_pipe
   import afu_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  cfg_type      cfg,
   afu_req_if.sink      req_bus,
   afu_rsp_if.source    rsp_bus
);

   logic va_ff, vb_ff, vc_ff, vo_ff;
   logic en_a, en_b, en_c, en_o;

   assign en_o = !vo_ff || rsp_bus.ready;
   assign en_c = !vc_ff || en_o;
   assign en_b = !vb_ff || en_c;
   assign en_a = !va_ff || en_b;
   assign req_bus.ready = en_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         if (en_a) begin
            va_ff <= req_bus.valid;
         end
         if (en_b) begin
            vb_ff <= va_ff;
         end
         if (en_c) begin
            vc_ff <= vb_ff;
         end
         if (en_o) begin
            vo_ff <= vc_ff;
         end
      end
   end

   // The sigmoid argument is clamped and offset to an unsigned position in [-8, 8).
   logic signed [DataW:0]   x_in;
   logic                    top_in;
   logic [DataW-1:0]        u_in;
   cmd_type                 cmd_a_ff;
   logic signed [DataW-1:0] v_a_ff, g_a_ff;
   logic                    top_a_ff;
   logic [DataW-1:0]        u_a_ff;

   always_comb begin
      if (cfg.mode == MODE_TANH) begin
         x_in = {req_bus.value, 1'b0};
      end else begin
         x_in = {req_bus.value[DataW-1], req_bus.value};
      end
      top_in = !x_in[DataW] && x_in[DataW-1];
      if (x_in[DataW] && !x_in[DataW-1]) begin
         u_in = '0;
      end else begin
         u_in = {!x_in[DataW-1], x_in[DataW-2:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (en_a) begin
         cmd_a_ff <= cmd_type'(req_bus.cmd);
         v_a_ff   <= req_bus.value;
         g_a_ff   <= req_bus.grad;
         top_a_ff <= top_in;
         u_a_ff   <= u_in;
      end
   end

   logic [SegW-1:0]         seg;
   logic [TabW-1:0]         lo_in, hi_in;
   logic signed [DataW:0]   op_a, op_b;
   logic signed [2*DataW+1:0] prod_in;
   cmd_type                 cmd_b_ff;
   logic signed [DataW-1:0] v_b_ff, g_b_ff;
   logic [TabW-1:0]         lo_b_ff, diff_b_ff;
   logic [PosW-1:0]         t_b_ff;
   logic signed [2*DataW+1:0] prod_b_ff;

   assign seg = u_a_ff[DataW-1:PosW];

   always_comb begin
      if (top_a_ff) begin
         lo_in = sig_point({1'b1, {SegW{1'b0}}});
         hi_in = lo_in;
      end else begin
         lo_in = sig_point({1'b0, seg});
         hi_in = sig_point({1'b0, seg} + 6'd1);
      end
      op_a = {v_a_ff[DataW-1], v_a_ff};
      if (cmd_a_ff == CMD_BACKWARD && cfg.mode == MODE_SIGMOID) begin
         op_b = ONE_Q - op_a;
      end else if (cmd_a_ff == CMD_BACKWARD && cfg.mode == MODE_TANH) begin
         op_b = op_a;
      end else begin
         op_b = $signed({4'b0, cfg.slope});
      end
   end

   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      if (en_b) begin
         cmd_b_ff  <= cmd_a_ff;
         v_b_ff    <= v_a_ff;
         g_b_ff    <= g_a_ff;
         lo_b_ff   <= lo_in;
         diff_b_ff <= hi_in - lo_in;
         t_b_ff    <= u_a_ff[PosW-1:0];
         prod_b_ff <= prod_in;
      end
   end

   logic [TabW+PosW-1:0]    interp;
   logic [TabW:0]           sig_val;
   logic signed [TabW+2:0]  tanh_val;
   logic signed [2*DataW-FracW+1:0] prod_sh;
   logic signed [2*DataW-FracW+2:0] tanh_d;
   logic                    v_pos;
   logic signed [DataW-1:0] res_in;
   logic signed [DataW:0]   d_in;
   cmd_type                 cmd_c_ff;
   logic signed [DataW-1:0] g_c_ff, res_c_ff;
   logic signed [DataW:0]   d_c_ff;

   always_comb begin
      interp   = (TabW+PosW)'(diff_b_ff) * (TabW+PosW)'(t_b_ff)
                 + (TabW+PosW)'(1 << (PosW-1));
      sig_val  = (TabW+1)'(lo_b_ff) + (TabW+1)'(interp[TabW+PosW-1:PosW]);
      tanh_val = $signed({1'b0, sig_val, 1'b0}) - (TabW+3)'(ONE_Q);
      prod_sh  = prod_b_ff[2*DataW+1:FracW];
      tanh_d   = (2*DataW-FracW+3)'(ONE_Q) - (2*DataW-FracW+3)'(prod_sh);
      v_pos    = !v_b_ff[DataW-1] && (v_b_ff != '0);
      case (cfg.mode)
         MODE_SIGMOID: begin
            res_in = $signed({{(DataW-TabW-1){1'b0}}, sig_val});
            d_in   = (DataW+1)'(sat16(WideW'(prod_sh)));
         end
         MODE_TANH: begin
            res_in = DataW'(tanh_val);
            d_in   = (DataW+1)'(sat16(WideW'(tanh_d)));
         end
         MODE_RELU: begin
            res_in = v_b_ff[DataW-1] ? '0 : v_b_ff;
            d_in   = v_pos ? ONE_Q : '0;
         end
         default: begin
            res_in = v_b_ff[DataW-1] ? sat16(WideW'(prod_sh)) : v_b_ff;
            d_in   = v_pos ? ONE_Q : $signed({4'b0, cfg.slope});
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en_c) begin
         cmd_c_ff <= cmd_b_ff;
         g_c_ff   <= g_b_ff;
         res_c_ff <= res_in;
         d_c_ff   <= d_in;
      end
   end

   logic signed [2*DataW:0]       prod2;
   logic signed [2*DataW-FracW:0] prod2_sh;
   logic signed [DataW-1:0]       out_ff;

   assign prod2    = d_c_ff * g_c_ff;
   assign prod2_sh = prod2[2*DataW:FracW];

   always_ff @(posedge clock) begin
      if (en_o) begin
         if (cmd_c_ff == CMD_BACKWARD) begin
            out_ff <= sat16(WideW'(prod2_sh));
         end else begin
            out_ff <= res_c_ff;
         end
      end
   end

   assign rsp_bus.valid  = vo_ff;
   assign rsp_bus.result = out_ff;

endmodule

`default_nettype wire
